// ----- rtl/core/sem_pkg.sv -----
// Shared types and constants for the Sobel edge magnitude core.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

    // Line store depth and derived column counter width
    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int MAX_HEIGHT = 4095;

    // Configuration register fields
    localparam int CFG_W = 12;
    localparam int ROW_W = 12;
    // Width used when comparing counters against clamped sizes
    localparam int EXT_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = CFG_W'(480);

    // Register indexes on the configuration port
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Luma weights over 65536
    localparam logic [15:0] WEIGHT_BLUE  = 16'd4732;
    localparam logic [15:0] WEIGHT_GREEN = 16'd46871;
    localparam logic [15:0] WEIGHT_RED   = 16'd13933;

    localparam int PIX_W  = 8;
    localparam int GRAD_W = 11;   // signed, holds +/-1020
    localparam int SUM_W  = 21;   // gx^2 + gy^2 at most 2080800
    localparam int BIT_W  = 3;    // square root bit index

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRAY,
        S_GRAD,
        S_SQ,
        S_SQRT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic gray_en;
        logic grad_en;
        logic sq_en;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic has_result;
        logic sqrt_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/core/sobel_edge_magnitude_core.sv -----
// Top level of the Sobel edge magnitude core: configuration registers and
// stream ports. Depends on sem_pkg, sem_ctrl and sem_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Sobel 3x3 edge magnitude over a raster-order BGR pixel stream. Each pixel
// is converted to 8-bit gray (luma weights 4732/46871/13933 over 65536,
// floored); two 2048-entry line stores and a 3x3 window give, for every
// pixel at column >= 2 and row >= 2, floor(sqrt(gx^2 + gy^2)) saturated at
// 255, with tlast on the final result of a frame. Border pixels are consumed
// and give no result. A border pixel passes through capture and line store
// read, gray conversion and gradient before the next acceptance; a pixel
// with a result then goes on through squaring, the bit-per-cycle square
// root and the output load, and waits while the output register stays full.
// A finished result waits in the output register while the next pixel is
// already taken and worked on. image_width (byte address 0) is clamped to
// 3..2048 and image_height (byte address 4) to 3..4095; write them only while
// the core is idle. Line stores come out of reset unwritten and need no
// clearing pass: entries not yet written are read only for border pixels.
module sobel_edge_magnitude_core
    import sem_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Pixel input: tdata = blue [7:0], green [15:8], red [23:16]
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,
    // Result output: tdata = edge_magnitude [7:0]; tlast = last_of_frame
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;
    logic             cfg_write;
    t_cmd             cmd;
    t_status          status;

    // Register write on the access phase; pready never stalls
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RESET;
            r_image_height <= IMAGE_HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register, zero-extended
    always_comb begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = 32'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = 32'(r_image_height);
            default:          prdata = '0;
        endcase
    end

    // Sequence one pixel transaction at a time
    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Counters, line stores, window, gradient, square root, output register
    sem_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_image_width   (r_image_width),
        .i_image_height  (r_image_height),
        .i_blue          (i_s_axis_tdata[7:0]),
        .i_green         (i_s_axis_tdata[15:8]),
        .i_red           (i_s_axis_tdata[23:16]),
        .o_out_valid     (o_m_axis_tvalid),
        .i_out_ready     (i_m_axis_tready),
        .o_out_magnitude (o_m_axis_tdata),
        .o_out_last      (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/core/sem_ctrl.sv -----
// Controller state machine of the Sobel edge magnitude core.
// Depends on sem_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module sem_ctrl
    import sem_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_GRAY;
            end
            S_GRAY: n_state = S_GRAD;
            S_GRAD: begin
                n_state = i_status.has_result ? S_SQ : S_IDLE;
            end
            S_SQ:   n_state = S_SQRT;
            S_SQRT: begin
                if (i_status.sqrt_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_GRAY: o_cmd.gray_en   = 1'b1;
            S_GRAD: o_cmd.grad_en   = 1'b1;
            S_SQ:   o_cmd.sq_en     = 1'b1;
            S_SQRT: o_cmd.sqrt_step = 1'b1;
            S_DONE: o_cmd.out_load  = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    a_accept_to_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_GRAY)
        else $error("accepted transaction did not advance to gray conversion");

    a_border_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRAD && !i_status.has_result) |=> r_state == S_IDLE)
        else $error("border pixel did not return to idle");

    a_sqrt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && !i_status.sqrt_last) |=> r_state == S_SQRT)
        else $error("square root left before its last step");

endmodule

`default_nettype wire

// ----- rtl/core/sem_datapath.sv -----
// Datapath of the Sobel edge magnitude core: counters, line stores, window,
// gradient, iterative square root and output register. Depends on sem_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sem_datapath
    import sem_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    input  wire logic [CFG_W-1:0]  i_image_width,
    input  wire logic [CFG_W-1:0]  i_image_height,
    input  wire logic [PIX_W-1:0]  i_blue,
    input  wire logic [PIX_W-1:0]  i_green,
    input  wire logic [PIX_W-1:0]  i_red,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [PIX_W-1:0]       o_out_magnitude,
    output logic                   o_out_last
);

    logic [PIX_W-1:0] r_upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_lower_mem [MAX_WIDTH];

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic [COL_W-1:0] r_idx;
    logic             r_has_result;
    logic             r_last;
    logic [PIX_W-1:0] r_blue;
    logic [PIX_W-1:0] r_green;
    logic [PIX_W-1:0] r_red;
    logic [PIX_W-1:0] r_top;
    logic [PIX_W-1:0] r_mid;
    logic [PIX_W-1:0] r_gray;
    logic [PIX_W-1:0] r_win [6];

    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;
    logic [SUM_W-1:0]         r_sum;
    logic [PIX_W-1:0]         r_root;
    logic [BIT_W-1:0]         r_bit;

    logic                     r_out_valid;
    logic [PIX_W-1:0]         r_out_magnitude;
    logic                     r_out_last;

    logic [EXT_W-1:0] w_eff;
    logic [EXT_W-1:0] h_eff;
    logic             end_row;
    logic             end_frame;
    logic [23:0]      luma_sum;
    logic signed [GRAD_W-1:0] t0, m0, b0, t1, b1, t2, m2, b2;
    logic signed [GRAD_W-1:0] gx, gy;
    logic [PIX_W-1:0]         trial;
    logic [2*PIX_W-1:0]       trial_sq;

    // Clamp the frame size to the supported range
    always_comb begin
        if (EXT_W'(i_image_width) < EXT_W'(3)) begin
            w_eff = EXT_W'(3);
        end else if (EXT_W'(i_image_width) > EXT_W'(MAX_WIDTH)) begin
            w_eff = EXT_W'(MAX_WIDTH);
        end else begin
            w_eff = EXT_W'(i_image_width);
        end
        if (EXT_W'(i_image_height) < EXT_W'(3)) begin
            h_eff = EXT_W'(3);
        end else if (EXT_W'(i_image_height) > EXT_W'(MAX_HEIGHT)) begin
            h_eff = EXT_W'(MAX_HEIGHT);
        end else begin
            h_eff = EXT_W'(i_image_height);
        end
    end

    assign end_row   = EXT_W'(r_col) >= (w_eff - EXT_W'(1));
    assign end_frame = end_row && (EXT_W'(r_row) >= (h_eff - EXT_W'(1)));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (end_frame) begin
            n_col = '0;
            n_row = '0;
        end else if (end_row) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Capture the transaction and its position in the frame
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx        <= r_col;
            r_has_result <= (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
            r_last       <= end_frame;
            r_blue       <= i_blue;
            r_green      <= i_green;
            r_red        <= i_red;
        end
    end

    // Line store read, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_top <= r_upper_mem[r_col];
            r_mid <= r_lower_mem[r_col];
        end
    end

    // Line store write: shift the column down by one row
    always_ff @(posedge i_clk) begin
        if (i_cmd.grad_en) begin
            r_upper_mem[r_idx] <= r_mid;
            r_lower_mem[r_idx] <= r_gray;
        end
    end

    assign luma_sum = 24'(WEIGHT_BLUE * r_blue) + 24'(WEIGHT_GREEN * r_green)
                    + 24'(WEIGHT_RED * r_red);

    always_ff @(posedge i_clk) begin
        if (i_cmd.gray_en) begin
            r_gray <= luma_sum[23:16];
        end
    end

    // Window: [0..2] older column top/mid/bottom, [3..5] newer column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else if (i_cmd.grad_en) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_top;
            r_win[4] <= r_mid;
            r_win[5] <= r_gray;
        end
    end

    assign t0 = GRAD_W'(r_win[0]);
    assign m0 = GRAD_W'(r_win[1]);
    assign b0 = GRAD_W'(r_win[2]);
    assign t1 = GRAD_W'(r_win[3]);
    assign b1 = GRAD_W'(r_win[5]);
    assign t2 = GRAD_W'(r_top);
    assign m2 = GRAD_W'(r_mid);
    assign b2 = GRAD_W'(r_gray);

    assign gx = (t2 - t0) + ((m2 - m0) <<< 1) + (b2 - b0);
    assign gy = (b0 - t0) + ((b1 - t1) <<< 1) + (b2 - t2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad_en) begin
            r_gx <= gx;
            r_gy <= gy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_en) begin
            r_sum <= SUM_W'(unsigned'((2*GRAD_W)'(r_gx * r_gx)))
                   + SUM_W'(unsigned'((2*GRAD_W)'(r_gy * r_gy)));
        end
    end

    // Restoring square root, one result bit per step, MSB first.
    // A sum of 65536 or more ends at 255 on its own.
    assign trial    = r_root | (PIX_W'(1) << r_bit);
    assign trial_sq = trial * trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_en) begin
            r_root <= '0;
            r_bit  <= BIT_W'(PIX_W - 1);
        end else if (i_cmd.sqrt_step) begin
            if (SUM_W'(trial_sq) <= r_sum) r_root <= trial;
            r_bit <= r_bit - BIT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_magnitude <= r_root;
            r_out_last      <= r_last;
        end
    end

    assign o_status.has_result = r_has_result;
    assign o_status.sqrt_last  = (r_bit == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_out_magnitude = r_out_magnitude;
    assign o_out_last      = r_out_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over one not yet taken");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_out_valid && r_out_magnitude == $past(r_root)))
        else $error("loaded result not presented");

endmodule

`default_nettype wire
